[hdl/dsrm_pkg.sv]
// Shared types and constants for the dot-star regex matcher.
// No dependencies; imported by the cell and the top level.
package dsrm_pkg;

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_TEXT   = 2'd2;

	localparam logic [7:0] SYM_STAR = 8'd42;
	localparam logic [7:0] SYM_DOT  = 8'd46;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic       restart;
		logic       advance;
		logic [7:0] text;
	} cmd_t;

endpackage

[hdl/dsrm_if.sv]
// Valid/ready channels of the dot-star regex matcher: input word and result word.
// Depends on nothing but the payload widths fixed here.
interface dsrm_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] symbol;

	modport source (output valid, output kind, output symbol, input ready);
	modport sink (input valid, input kind, input symbol, output ready);
endinterface

interface dsrm_result_if;
	logic valid;
	logic ready;
	logic matched;
	logic status;

	modport source (output valid, output matched, output status, input ready);
	modport sink (input valid, input matched, input status, output ready);
endinterface

[hdl/dsrm_cell.sv]
// One pattern position of the match row: holds its pattern byte and match bit.
// Depends on dsrm_pkg (cmd_t, symbol codes).
module dsrm_cell import dsrm_pkg::*; #(
	parameter int IDX = 1
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       wr,
	input  logic [7:0] wr_sym,
	input  logic       active,
	input  logic [7:0] prev_sym,
	input  logic       m1_q,
	input  logic       m2_nxt,
	output logic [7:0] sym_eff,
	output logic       bit_q,
	output logic       bit_nxt
);

	localparam logic FIRST = (IDX == 1);

	logic [7:0] sym_q;
	logic       is_star;
	logic       prev_hit;
	logic       own_hit;
	logic       nb;

	assign sym_eff  = wr ? wr_sym : sym_q;
	assign is_star  = (sym_eff == SYM_STAR);
	assign prev_hit = (prev_sym == SYM_DOT) || (prev_sym == cmd.text);
	assign own_hit  = (sym_eff == SYM_DOT) || (sym_eff == cmd.text);

	always_comb begin
		nb = 1'b0;
		if (active) begin
			if (cmd.restart) begin
				nb = is_star && !FIRST && m2_nxt;
			end else if (is_star) begin
				nb = !FIRST && (m2_nxt || (prev_hit && bit_q));
			end else begin
				nb = own_hit && m1_q;
			end
		end
	end

	assign bit_nxt = (cmd.restart || cmd.advance) ? nb : bit_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			sym_q <= wr_sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else begin
			bit_q <= bit_nxt;
		end
	end

endmodule

[hdl/dot_star_regex_matcher_core.sv]
// Dot-star regex matcher: row of PAT_MAX cells, one per pattern prefix.
// Result: the result word is registered as the input word is taken and is valid in the cycle after.
// Throughput: one word per cycle while result words are taken; the row update ripples through star cells.
// Reset: pattern length zero, only match bit zero set, pattern bytes undefined.
// Depends on dsrm_pkg, dsrm_if (dsrm_item_if, dsrm_result_if) and dsrm_cell.
module dot_star_regex_matcher_core import dsrm_pkg::*; #(
	parameter int PAT_MAX = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	dsrm_item_if.sink     item,
	dsrm_result_if.source result
);

	localparam int LW = $clog2(PAT_MAX + 1);

	logic [LW-1:0]    len_q;
	logic [LW-1:0]    len_nxt;
	logic             row0_q;
	logic             row0_nxt;
	logic [PAT_MAX:0] row_q;
	logic [PAT_MAX:0] row_nxt;
	logic [7:0]       sym_eff [PAT_MAX];
	logic             accept;
	logic             clr;
	logic             app;
	logic             app_ok;
	logic             txt;
	cmd_t             cmd;
	logic             out_valid_q;
	logic             matched_q;
	logic             status_q;

	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	always_comb begin
		clr = 1'b0;
		app = 1'b0;
		txt = 1'b0;
		unique case (item.kind)
			KIND_CLEAR:  clr = accept;
			KIND_APPEND: app = accept;
			KIND_TEXT:   txt = accept;
			default:     ;
		endcase
	end

	assign app_ok = app && (len_q != LW'(PAT_MAX));

	always_comb begin
		len_nxt = len_q;
		if (clr) begin
			len_nxt = '0;
		end else if (app_ok) begin
			len_nxt = len_q + LW'(1);
		end
	end

	assign cmd.restart = clr || app_ok;
	assign cmd.advance = txt;
	assign cmd.text    = item.symbol;

	assign row0_nxt   = cmd.restart ? 1'b1 : (cmd.advance ? 1'b0 : row0_q);
	assign row_q[0]   = row0_q;
	assign row_nxt[0] = row0_nxt;

	for (genvar j = 1; j <= PAT_MAX; j++) begin : g_cell
		localparam logic [LW-1:0] JV = LW'(j);
		logic [7:0] prev_sym;
		logic       m2_nxt;

		if (j == 1) begin : g_first
			assign prev_sym = '0;
			assign m2_nxt   = 1'b0;
		end else begin : g_rest
			assign prev_sym = sym_eff[j-2];
			assign m2_nxt   = row_nxt[j-2];
		end

		dsrm_cell #(
			.IDX(j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.wr      (app_ok && (len_q == JV - LW'(1))),
			.wr_sym  (item.symbol),
			.active  (JV <= len_nxt),
			.prev_sym(prev_sym),
			.m1_q    (row_q[j-1]),
			.m2_nxt  (m2_nxt),
			.sym_eff (sym_eff[j-1]),
			.bit_q   (row_q[j]),
			.bit_nxt (row_nxt[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			row0_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			len_q  <= len_nxt;
			row0_q <= row0_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			matched_q <= row_nxt[len_nxt];
			status_q  <= (app && !app_ok) ? STATUS_FULL : STATUS_OK;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.matched = matched_q;
	assign result.status  = status_q;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(PAT_MAX))
		else $error("pattern length out of range");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.kind == KIND_APPEND && len_q == LW'(PAT_MAX))
		|=> (result.status == STATUS_FULL) && $stable(len_q))
		else $error("full append not flagged or changed length");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.kind == KIND_CLEAR)
		|=> result.matched && (result.status == STATUS_OK) && (len_q == '0) && row0_q)
		else $error("clear did not restart pattern");

	a_text_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.kind == KIND_TEXT) |=> !row0_q && out_valid_q)
		else $error("text word left empty-prefix bit set");

endmodule

[tb/sv/dot_star_regex_matcher_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for dot_star_regex_matcher_core: directed table plus random
// pattern/text sequences, each result checked against a row predictor or pinned row.
// Depends on dsrm_pkg, dsrm_if and the core RTL.
module dot_star_regex_matcher_core_tb;
	import dsrm_pkg::*;

	localparam int PAT_MAX = 16;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_B = 8'h62;

	typedef struct {
		logic matched;
		logic status;
	} verdict_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol;
		logic       pinned;
		logic       matched;
		logic       status;
	} dir_row_t;

	logic clk;
	logic arst_n;

	dsrm_item_if   item_ch();
	dsrm_result_if result_ch();

	dot_star_regex_matcher_core #(.PAT_MAX(PAT_MAX)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// predictor state
	logic [7:0]       pat_mem [PAT_MAX];
	int               pat_len = 0;
	logic [PAT_MAX:0] prefix_row = {{PAT_MAX{1'b0}}, 1'b1};

	verdict_t pending_q[$];
	dir_row_t typed_q[$];
	int       err_count = 0;
	int       words_sent = 0;
	int       quiet_cycles = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	bit       hold_req = 1'b0;
	int       hold_left = 0;

	// leading star, star after star, pattern full (status), unused kind
	dir_row_t dir_rows [26] = '{
		'{KIND_SPARE,  8'hFF,    1'b1, 1'b1, STATUS_OK},
		'{KIND_TEXT,   8'h00,    1'b1, 1'b0, STATUS_OK},
		'{KIND_CLEAR,  8'h00,    1'b1, 1'b1, STATUS_OK},
		'{KIND_APPEND, SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_TEXT,   SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_TEXT,   SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_CLEAR,  8'hFF,    1'b1, 1'b1, STATUS_OK},
		'{KIND_APPEND, SYM_DOT,  1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, 8'h00,    1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, 8'hFF,    1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, CH_A,     1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, CH_B,     1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, 8'h80,    1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, 8'h7F,    1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, SYM_STAR, 1'b0, 1'b0, STATUS_OK},
		'{KIND_APPEND, 8'hFF,    1'b1, 1'b1, STATUS_FULL},
		'{KIND_TEXT,   8'h55,    1'b0, 1'b0, STATUS_OK}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void restart_prefix_row();
		prefix_row = {{PAT_MAX{1'b0}}, 1'b1};
		for (int j = 2; j <= pat_len; j++) begin
			if (pat_mem[j-1] == SYM_STAR)
				prefix_row[j] = prefix_row[j-2];
		end
	endfunction

	function automatic void predict_word(input logic [1:0] k, input logic [7:0] s,
			output logic m, output logic st);
		logic [PAT_MAX:0] nxt;
		logic [7:0]       pc;
		logic [7:0]       prev;
		st = STATUS_OK;
		unique case (k)
			KIND_CLEAR: begin
				pat_len = 0;
				restart_prefix_row();
			end
			KIND_APPEND: begin
				if (pat_len < PAT_MAX) begin
					pat_mem[pat_len] = s;
					pat_len++;
					restart_prefix_row();
				end else begin
					st = STATUS_FULL;
				end
			end
			KIND_TEXT: begin
				nxt = '0;
				for (int j = 1; j <= pat_len; j++) begin
					pc = pat_mem[j-1];
					if (pc == SYM_STAR) begin
						if (j > 1) begin
							prev = pat_mem[j-2];
							nxt[j] = nxt[j-2] |
								(((prev == SYM_DOT) || (prev == s)) & prefix_row[j]);
						end
					end else if (pc == SYM_DOT || pc == s) begin
						nxt[j] = prefix_row[j-1];
					end
				end
				prefix_row = nxt;
			end
			default: ;
		endcase
		m = prefix_row[pat_len];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_count++;
	endtask

	always @(posedge clk) begin : scoreboard
		verdict_t want;
		dir_row_t pin;
		logic     m;
		logic     st;
		if (arst_n) begin
			quiet_cycles++;
			if (result_ch.valid && result_ch.ready) begin
				quiet_cycles = 0;
				if (pending_q.size() == 0) begin
					report_mismatch($sformatf("result word with none pending (matched %b status %b)",
						result_ch.matched, result_ch.status));
				end else begin
					want = pending_q.pop_front();
					if (result_ch.matched !== want.matched)
						report_mismatch($sformatf("matched %b, want %b",
							result_ch.matched, want.matched));
					if (result_ch.status !== want.status)
						report_mismatch($sformatf("status %b, want %b",
							result_ch.status, want.status));
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				quiet_cycles = 0;
				predict_word(item_ch.kind, item_ch.symbol, m, st);
				if (typed_q.size() > 0) begin
					pin = typed_q.pop_front();
					if (pin.pinned) begin
						m = pin.matched;
						st = pin.status;
					end
				end
				want.matched = m;
				want.status = st;
				pending_q.push_back(want);
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_word(input logic [1:0] k, input logic [7:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= k;
		item_ch.symbol <= s;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] text_pick();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return CH_A;
		if (r < 90)
			return CH_B;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pattern_pick();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return CH_A;
		if (r < 60)
			return CH_B;
		if (r < 75)
			return SYM_DOT;
		if (r < 95)
			return SYM_STAR;
		return 8'($urandom);
	endfunction

	// mostly clear / pattern / text runs; text often built to fit the pattern
	task automatic run_random(input int count);
		logic [7:0] pat[$];
		logic [7:0] txt[$];
		logic [7:0] c;
		int         stop_at;
		int         r;
		int         plen;
		int         i;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 5) begin
				send_word(2'($urandom_range(3)), 8'($urandom));
			end else begin
				if (r >= 12)
					send_word(KIND_CLEAR, 8'($urandom));
				plen = ($urandom_range(9) == 0) ? $urandom_range(14, 19) : $urandom_range(7);
				pat.delete();
				repeat (plen) pat.push_back(pattern_pick());
				foreach (pat[n]) send_word(KIND_APPEND, pat[n]);
				txt.delete();
				if ($urandom_range(1)) begin
					i = 0;
					while (i < pat.size() && i < PAT_MAX) begin
						c = pat[i];
						if (i + 1 < pat.size() && i + 1 < PAT_MAX && pat[i+1] == SYM_STAR) begin
							repeat ($urandom_range(3))
								txt.push_back(c == SYM_DOT ? text_pick() : c);
							i += 2;
						end else begin
							if (c != SYM_STAR)
								txt.push_back(c == SYM_DOT ? text_pick() : c);
							i++;
						end
					end
					if (txt.size() > 0 && $urandom_range(4) == 0)
						txt[$urandom_range(txt.size() - 1)] = text_pick();
				end else begin
					repeat ($urandom_range(10)) txt.push_back(text_pick());
				end
				foreach (txt[n]) send_word(KIND_TEXT, txt[n]);
			end
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_CLEAR;
		item_ch.symbol = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 21;
		recv_idle_pct = 88;
		foreach (dir_rows[n]) begin
			typed_q.push_back(dir_rows[n]);
			send_word(dir_rows[n].kind, dir_rows[n].symbol);
		end
		run_random(660);
		wait_drained();

		send_idle_pct = 88;
		recv_idle_pct = 21;
		run_random(660);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		run_random(660);
		wait_drained();

		repeat (4) @(negedge clk);
		if (err_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/dsrm_pkg.sv
hdl/dsrm_if.sv
hdl/dsrm_cell.sv
hdl/dot_star_regex_matcher_core.sv
tb/sv/dot_star_regex_matcher_core_tb.sv
